/* design/cmw_pkg.sv */
`default_nettype none
package cmw_pkg;

	// geometry registers held on the block and level slots of the hierarchy word
	localparam int CMW_GEOM_LEVELS = 4;
	localparam int CMW_LEVEL_SLOTS = 8;
	localparam int CMW_MAX_LEVELS  = 4;

	// configuration register indexes
	localparam logic [2:0] CFG_DLINE     = 3'd0;
	localparam logic [2:0] CFG_HIERARCHY = 3'd1;
	localparam logic [2:0] CFG_GEOM_L1   = 3'd2;
	localparam logic [2:0] CFG_GEOM_L2   = 3'd3;
	localparam logic [2:0] CFG_GEOM_L3   = 3'd4;
	localparam logic [2:0] CFG_GEOM_L4   = 3'd5;

	// item actions
	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_RANGE  = 2'd1;
	localparam logic [1:0] ACT_SETWAY = 2'd2;

	// operation kinds
	localparam logic OP_BY_ADDR   = 1'b0;
	localparam logic OP_BY_SETWAY = 1'b1;

	localparam logic [2:0] DATA_TYPE_MIN = 3'd2;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_RANGE  = 2'd1,
		MODE_SETWAY = 2'd2
	} walk_mode_t;

	typedef logic [CMW_GEOM_LEVELS-1:0][31:0] geom_arr_t;

	typedef struct packed {
		logic        found;
		logic [2:0]  level;
	} lvl_find_t;

	typedef struct packed {
		logic        last;
		logic [2:0]  level;
		logic [9:0]  way;
		logic [14:0] set;
	} sw_next_t;

	// lowest level at or above from, below the level of coherence, holding data
	function automatic lvl_find_t find_level(input logic [31:0] hier, input logic [3:0] from);
		lvl_find_t r;
		logic [2:0] loc;
		r.found = 1'b0;
		r.level = 3'd0;
		loc = hier[26:24];
		for (int l = CMW_LEVEL_SLOTS - 1; l >= 0; l--) begin
			if ((4'(l) >= from) && (3'(l) < loc) && (l < CMW_MAX_LEVELS) &&
			    (hier[3*l +: 3] >= DATA_TYPE_MIN)) begin
				r.found = 1'b1;
				r.level = 3'(l);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/cache_maintenance_walker.sv */
// channel   | handshake                     | payload
// ----------+-------------------------------+------------------------------------------
// item      | item_valid / item_stall       | action, start_address, byte_count
// result    | result_valid / result_stall   | op_kind, operand, last_op
// config    | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// An item is taken into the input register and handled there against the walk state, and
// the result of a tick lands in the output register; one item per cycle is sustained while
// the result side does not stall.
// A stalled result holds the output register and stalls the item side in the same cycle.
// Reset clears the walk state and configuration to their reset values; no clearing pass.
// cfg_ready is always high.
`default_nettype none
module cache_maintenance_walker import cmw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  action,
	input  wire logic [63:0] start_address,
	input  wire logic [63:0] byte_count,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             op_kind,
	output logic [63:0]      operand,
	output logic             last_op,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [3:0]  dline_q;
	logic [31:0] hier_q;
	geom_arr_t   geom_q;

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [63:0] addr_s1;
	logic [63:0] count_s1;

	walk_mode_t  mode_q, mode_d;
	logic [63:0] cur_addr_q, cur_addr_d;
	logic [63:0] end_addr_q, end_addr_d;
	logic [2:0]  level_q, level_d;
	logic [9:0]  way_q, way_d;
	logic [14:0] set_q, set_d;

	logic        out_valid_q;
	logic        op_kind_q;
	logic [63:0] operand_q;
	logic        last_q;

	logic        out_free;
	logic        go_s1;
	logic [63:0] line_len;
	logic [63:0] range_start;
	logic [63:0] range_end;
	logic [63:0] next_addr;
	logic        range_last;
	lvl_find_t   first_lvl;
	logic [63:0] sw_operand;
	sw_next_t    sw_nxt;

	logic        res_valid;
	logic        res_kind;
	logic [63:0] res_operand;
	logic        res_last;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dline_q <= 4'd4;
			hier_q  <= '0;
			geom_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DLINE:     dline_q   <= cfg_data[3:0];
				CFG_HIERARCHY: hier_q    <= cfg_data;
				CFG_GEOM_L1:   geom_q[0] <= cfg_data;
				CFG_GEOM_L2:   geom_q[1] <= cfg_data;
				CFG_GEOM_L3:   geom_q[2] <= cfg_data;
				CFG_GEOM_L4:   geom_q[3] <= cfg_data;
				default:       ;
			endcase
		end
	end

	// handshake between input and output registers
	assign out_free   = !out_valid_q || !result_stall;
	assign go_s1      = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1 <= action;
			addr_s1   <= start_address;
			count_s1  <= byte_count;
		end
	end

	// address arithmetic
	assign line_len    = 64'd4 << dline_q;
	assign range_start = addr_s1 & ~(line_len - 64'd1);
	assign range_end   = addr_s1 + count_s1;
	assign next_addr   = cur_addr_q + line_len;
	assign range_last  = (next_addr < cur_addr_q) || (next_addr >= end_addr_q);
	assign first_lvl   = find_level(hier_q, 4'd0);

	cmw_setway_step u_setway (
		.hierarchy_id (hier_q),
		.geometry     (geom_q),
		.level        (level_q),
		.way          (way_q),
		.set          (set_q),
		.operand      (sw_operand),
		.nxt          (sw_nxt)
	);

	// next walk state
	always_comb begin
		mode_d     = mode_q;
		cur_addr_d = cur_addr_q;
		end_addr_d = end_addr_q;
		level_d    = level_q;
		way_d      = way_q;
		set_d      = set_q;
		if (go_s1) begin
			case (mode_q)
				MODE_IDLE: begin
					if (action_s1 == ACT_RANGE) begin
						if ((addr_s1 != '0) && (count_s1 != '0) && (range_start < range_end)) begin
							cur_addr_d = range_start;
							end_addr_d = range_end;
							mode_d     = MODE_RANGE;
						end
					end else if (action_s1 == ACT_SETWAY) begin
						if (first_lvl.found) begin
							level_d = first_lvl.level;
							way_d   = '0;
							set_d   = '0;
							mode_d  = MODE_SETWAY;
						end
					end
				end
				MODE_RANGE: begin
					if (action_s1 == ACT_TICK) begin
						cur_addr_d = next_addr;
						if (range_last) begin
							mode_d = MODE_IDLE;
						end
					end
				end
				MODE_SETWAY: begin
					if (action_s1 == ACT_TICK) begin
						level_d = sw_nxt.level;
						way_d   = sw_nxt.way;
						set_d   = sw_nxt.set;
						if (sw_nxt.last) begin
							mode_d = MODE_IDLE;
						end
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
		end
	end

	// result of a tick
	always_comb begin
		res_valid   = 1'b0;
		res_kind    = OP_BY_ADDR;
		res_operand = cur_addr_q;
		res_last    = range_last;
		if (valid_s1 && (action_s1 == ACT_TICK)) begin
			case (mode_q)
				MODE_RANGE: begin
					res_valid = 1'b1;
				end
				MODE_SETWAY: begin
					res_valid   = 1'b1;
					res_kind    = OP_BY_SETWAY;
					res_operand = sw_operand;
					res_last    = sw_nxt.last;
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	// walk state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			cur_addr_q <= '0;
			end_addr_q <= '0;
			level_q    <= '0;
			way_q      <= '0;
			set_q      <= '0;
		end else begin
			mode_q     <= mode_d;
			cur_addr_q <= cur_addr_d;
			end_addr_q <= end_addr_d;
			level_q    <= level_d;
			way_q      <= way_d;
			set_q      <= set_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res_valid) begin
			op_kind_q <= res_kind;
			operand_q <= res_operand;
			last_q    <= res_last;
		end
	end

	assign result_valid = out_valid_q;
	assign op_kind      = op_kind_q;
	assign operand      = operand_q;
	assign last_op      = last_q;

endmodule
`default_nettype wire

/* design/cmw_setway_step.sv */
`default_nettype none
module cmw_setway_step import cmw_pkg::*; (
	input  wire logic [31:0] hierarchy_id,
	input  wire geom_arr_t   geometry,
	input  wire logic [2:0]  level,
	input  wire logic [9:0]  way,
	input  wire logic [14:0] set,
	output logic [63:0]      operand,
	output sw_next_t         nxt
);

	logic [31:0] g;
	logic [3:0]  set_lsb;
	logic [9:0]  ways_m1;
	logic [14:0] sets_m1;
	logic [3:0]  way_lg;
	logic [5:0]  way_lsb;
	lvl_find_t   nl;

	// geometry of the current level, zero beyond the held registers
	always_comb begin
		if (level < 3'(CMW_GEOM_LEVELS)) begin
			g = geometry[level[1:0]];
		end else begin
			g = '0;
		end
	end

	assign set_lsb = 4'(g[2:0]) + 4'd4;
	assign ways_m1 = g[12:3];
	assign sets_m1 = g[27:13];

	// ceil log2 of the way count is the bit length of ways-1
	always_comb begin
		way_lg = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (ways_m1[i]) begin
				way_lg = 4'(i + 1);
			end
		end
	end

	assign way_lsb = 6'd32 - 6'(way_lg);

	// packed way, set and level word
	assign operand = (64'(way) << way_lsb) | (64'(set) << set_lsb) | (64'(level) << 1);

	assign nl = find_level(hierarchy_id, 4'(level) + 4'd1);

	// set inner, way outer, then the next data level
	always_comb begin
		nxt.last  = 1'b0;
		nxt.level = level;
		nxt.way   = way;
		nxt.set   = set + 15'd1;
		if (set >= sets_m1) begin
			nxt.set = '0;
			if (way >= ways_m1) begin
				nxt.way = '0;
				if (nl.found) begin
					nxt.level = nl.level;
				end else begin
					nxt.last = 1'b1;
				end
			end else begin
				nxt.way = way + 10'd1;
			end
		end
	end

endmodule
`default_nettype wire
